### sv/bcma_pkg.sv
`default_nettype none
package bcma_pkg;

  localparam int MAX_WINDOW = 16;
  localparam int COORD_BITS = 16;

  localparam int FIELD_BITS = 15;
  localparam int LEN_BITS   = 5;
  localparam int TOTAL_BITS = COORD_BITS + $clog2(MAX_WINDOW);
  localparam int SLOT_BITS  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int LANES      = 4;

  localparam int LANE_LEFT   = 0;
  localparam int LANE_TOP    = 1;
  localparam int LANE_RIGHT  = 2;
  localparam int LANE_BOTTOM = 3;

  typedef logic [FIELD_BITS-1:0] field_t;
  typedef logic [COORD_BITS-1:0] corner_t;
  typedef logic [TOTAL_BITS-1:0] total_t;
  typedef logic [LEN_BITS-1:0]   len_t;
  typedef logic [SLOT_BITS-1:0]  slot_t;

  typedef corner_t [LANES-1:0] corner_vec_t;
  typedef total_t  [LANES-1:0] total_vec_t;

  localparam field_t FIELD_MAX = '1;

  typedef enum logic [1:0] {
    STATUS_EMPTY      = 2'd0,
    STATUS_NO_OVERLAP = 2'd1,
    STATUS_AVERAGED   = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    CFG_WINDOW_LENGTH = 3'd0,
    CFG_INIT_X        = 3'd1,
    CFG_INIT_Y        = 3'd2,
    CFG_INIT_WIDTH    = 3'd3,
    CFG_INIT_HEIGHT   = 3'd4
  } cfg_index_t;

  typedef struct packed {
    field_t box_x;
    field_t box_y;
    field_t box_width;
    field_t box_height;
  } in_box_t;

  typedef struct packed {
    field_t  out_x;
    field_t  out_y;
    field_t  out_width;
    field_t  out_height;
    status_t out_status;
  } out_box_t;

  typedef struct packed {
    logic        we;
    logic [2:0]  index;
    field_t      data;
  } cfg_wr_t;

  typedef struct packed {
    in_box_t     box;
    corner_vec_t corner;
    logic        zero_area;
  } q_item_t;

  typedef struct packed {
    logic       start;
    len_t       divisor;
    total_vec_t dividend;
  } div_req_t;

  function automatic field_t sat_field(corner_t v);
    return (v > FIELD_MAX) ? FIELD_MAX : field_t'(v);
  endfunction

  function automatic corner_t far_corner(field_t pos, field_t len);
    logic [FIELD_BITS:0] sum;
    sum = {1'b0, pos} + {1'b0, len};
    return corner_t'(sum);
  endfunction

endpackage
`default_nettype wire

### sv/bcma_front.sv
`default_nettype none
module bcma_front (
  input  wire                bcma_pkg::in_box_t in_data,
  input  wire                in_valid,
  output logic               in_ready,
  input  wire                q_full,
  input  wire                priming,
  input  wire                bcma_pkg::cfg_wr_t cfg_wr,
  output logic               push,
  output bcma_pkg::q_item_t  push_item
);

  // hold off while the queue is full, during a configuration write and while the window is being re-primed
  assign in_ready = !q_full && !priming && !cfg_wr.we;
  assign push     = in_valid && in_ready;

  always_comb begin
    push_item.box       = in_data;
    push_item.zero_area = (in_data.box_width == '0) || (in_data.box_height == '0);
    push_item.corner[bcma_pkg::LANE_LEFT]   = bcma_pkg::corner_t'(in_data.box_x);
    push_item.corner[bcma_pkg::LANE_TOP]    = bcma_pkg::corner_t'(in_data.box_y);
    push_item.corner[bcma_pkg::LANE_RIGHT]  =
      bcma_pkg::far_corner(in_data.box_x, in_data.box_width);
    push_item.corner[bcma_pkg::LANE_BOTTOM] =
      bcma_pkg::far_corner(in_data.box_y, in_data.box_height);
  end

endmodule
`default_nettype wire

### sv/bcma_queue.sv
`default_nettype none
module bcma_queue (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                push,
  input  wire                bcma_pkg::q_item_t push_item,
  input  wire                pop,
  output bcma_pkg::q_item_t  head,
  output logic               full,
  output logic               empty
);

  localparam int DEPTH    = 2;
  localparam int PTR_BITS = $clog2(DEPTH);
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  typedef logic [PTR_BITS-1:0] ptr_t;
  typedef logic [CNT_BITS-1:0] cnt_t;

  bcma_pkg::q_item_t mem_r [DEPTH];
  ptr_t wr_ptr_r, wr_ptr_nxt;
  ptr_t rd_ptr_r, rd_ptr_nxt;
  cnt_t count_r, count_nxt;

  assign full  = (count_r == cnt_t'(DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  function automatic ptr_t bump(ptr_t p);
    return (p == ptr_t'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    wr_ptr_nxt = push ? bump(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? bump(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

### sv/bcma_divider.sv
`default_nettype none
module bcma_divider (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   bcma_pkg::div_req_t req,
  output logic                  busy,
  output bcma_pkg::total_vec_t  quotient
);

  localparam int TB       = bcma_pkg::TOTAL_BITS;
  localparam int LB       = bcma_pkg::LEN_BITS;
  localparam int CNT_BITS = $clog2(TB + 1);

  typedef logic [CNT_BITS-1:0] cnt_t;
  typedef logic [LB:0]         wide_rem_t;

  // all four totals share the divisor and the step counter, one bit per cycle
  bcma_pkg::total_vec_t quo_r, quo_nxt;
  bcma_pkg::len_t       rem_r [bcma_pkg::LANES];
  bcma_pkg::len_t       rem_nxt [bcma_pkg::LANES];
  bcma_pkg::len_t       div_r, div_nxt;
  cnt_t                 cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;

  assign busy     = busy_r;
  assign quotient = quo_r;

  always_comb begin
    wide_rem_t sh;
    logic      ge;
    sh       = '0;
    ge       = 1'b0;
    quo_nxt  = quo_r;
    div_nxt  = div_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    for (int k = 0; k < bcma_pkg::LANES; k++) begin
      rem_nxt[k] = rem_r[k];
    end
    if (req.start) begin
      quo_nxt  = req.dividend;
      div_nxt  = req.divisor;
      cnt_nxt  = cnt_t'(TB);
      busy_nxt = 1'b1;
      for (int k = 0; k < bcma_pkg::LANES; k++) begin
        rem_nxt[k] = '0;
      end
    end else if (busy_r) begin
      for (int k = 0; k < bcma_pkg::LANES; k++) begin
        sh         = {rem_r[k], quo_r[k][TB-1]};
        ge         = (sh >= {1'b0, div_r});
        rem_nxt[k] = ge ? bcma_pkg::len_t'(sh - {1'b0, div_r}) : bcma_pkg::len_t'(sh);
        quo_nxt[k] = {quo_r[k][TB-2:0], ge};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == cnt_t'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    div_r <= div_nxt;
    for (int k = 0; k < bcma_pkg::LANES; k++) begin
      rem_r[k] <= rem_nxt[k];
    end
  end

endmodule
`default_nettype wire

### sv/bcma_back.sv
`default_nettype none
module bcma_back (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   bcma_pkg::cfg_wr_t cfg_wr,
  output logic                  priming,
  input  wire                   q_empty,
  input  wire                   bcma_pkg::q_item_t q_head,
  output logic                  pop,
  output bcma_pkg::div_req_t    div_req,
  input  wire                   div_busy,
  input  wire                   bcma_pkg::total_vec_t div_quotient,
  output logic                  out_valid,
  input  wire                   out_ready,
  output bcma_pkg::out_box_t    out_data
);

  typedef enum logic {ST_IDLE, ST_DIV} state_t;

  localparam int MW = bcma_pkg::MAX_WINDOW;
  localparam int SB = bcma_pkg::SLOT_BITS;

  state_t                 state_r, state_nxt;
  bcma_pkg::len_t         win_r, win_nxt;
  bcma_pkg::in_box_t      init_r, init_nxt;
  logic                   prime_r, prime_nxt;
  bcma_pkg::corner_vec_t  ring_r [MW];
  bcma_pkg::total_vec_t   tot_r, tot_nxt;
  bcma_pkg::slot_t        slot_r, slot_nxt;
  bcma_pkg::in_box_t      prev_r, prev_nxt;
  bcma_pkg::out_box_t     out_r, out_nxt;
  logic                   out_valid_r, out_valid_nxt;

  logic                   ring_we;
  logic                   ring_fill;
  bcma_pkg::corner_vec_t  init_corner;
  bcma_pkg::len_t         n_act;
  bcma_pkg::slot_t        s;
  logic [SB:0]            slot_inc;
  logic                   out_free;
  logic                   overlap;
  bcma_pkg::corner_t      mean [bcma_pkg::LANES];
  bcma_pkg::in_box_t      avg_box;

  assign priming   = prime_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_free  = !out_valid_r || out_ready;

  // window length 0 acts as 1, anything above the ring depth as the depth
  always_comb begin
    if (win_r == '0) begin
      n_act = bcma_pkg::len_t'(1);
    end else if (win_r > MW) begin
      n_act = bcma_pkg::len_t'(MW);
    end else begin
      n_act = win_r;
    end
  end

  always_comb begin
    s        = (slot_r >= n_act) ? '0 : slot_r;
    slot_inc = {1'b0, s} + 1'b1;
  end

  always_comb begin
    init_corner[bcma_pkg::LANE_LEFT]   = bcma_pkg::corner_t'(init_r.box_x);
    init_corner[bcma_pkg::LANE_TOP]    = bcma_pkg::corner_t'(init_r.box_y);
    init_corner[bcma_pkg::LANE_RIGHT]  =
      bcma_pkg::far_corner(init_r.box_x, init_r.box_width);
    init_corner[bcma_pkg::LANE_BOTTOM] =
      bcma_pkg::far_corner(init_r.box_y, init_r.box_height);
  end

  // overlap against the previous box, edges at full 16 bit precision
  always_comb begin
    logic [bcma_pkg::FIELD_BITS:0] lo_x, lo_y, hi_x, hi_y, ar, ab, pr, pb;
    ar   = {1'b0, q_head.box.box_x} + {1'b0, q_head.box.box_width};
    ab   = {1'b0, q_head.box.box_y} + {1'b0, q_head.box.box_height};
    pr   = {1'b0, prev_r.box_x} + {1'b0, prev_r.box_width};
    pb   = {1'b0, prev_r.box_y} + {1'b0, prev_r.box_height};
    lo_x = {1'b0, (q_head.box.box_x > prev_r.box_x) ? q_head.box.box_x : prev_r.box_x};
    lo_y = {1'b0, (q_head.box.box_y > prev_r.box_y) ? q_head.box.box_y : prev_r.box_y};
    hi_x = (ar < pr) ? ar : pr;
    hi_y = (ab < pb) ? ab : pb;
    overlap = (hi_x > lo_x) && (hi_y > lo_y);
  end

  always_comb begin
    for (int k = 0; k < bcma_pkg::LANES; k++) begin
      mean[k] = bcma_pkg::corner_t'(div_quotient[k]);
    end
    avg_box.box_x      = bcma_pkg::sat_field(mean[bcma_pkg::LANE_LEFT]);
    avg_box.box_y      = bcma_pkg::sat_field(mean[bcma_pkg::LANE_TOP]);
    avg_box.box_width  = bcma_pkg::sat_field(
      (mean[bcma_pkg::LANE_RIGHT] > mean[bcma_pkg::LANE_LEFT]) ?
      mean[bcma_pkg::LANE_RIGHT] - mean[bcma_pkg::LANE_LEFT] : '0);
    avg_box.box_height = bcma_pkg::sat_field(
      (mean[bcma_pkg::LANE_BOTTOM] > mean[bcma_pkg::LANE_TOP]) ?
      mean[bcma_pkg::LANE_BOTTOM] - mean[bcma_pkg::LANE_TOP] : '0);
  end

  always_comb begin
    state_nxt     = state_r;
    win_nxt       = win_r;
    init_nxt      = init_r;
    prime_nxt     = 1'b0;
    tot_nxt       = tot_r;
    slot_nxt      = slot_r;
    prev_nxt      = prev_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    ring_we       = 1'b0;
    ring_fill     = 1'b0;
    pop           = 1'b0;
    div_req.start    = 1'b0;
    div_req.divisor  = n_act;
    for (int k = 0; k < bcma_pkg::LANES; k++) begin
      div_req.dividend[k] = tot_r[k] - bcma_pkg::total_t'(ring_r[s][k]) +
                            bcma_pkg::total_t'(q_head.corner[k]);
    end

    if (cfg_wr.we) begin
      prime_nxt = 1'b1;
      unique case (cfg_wr.index)
        bcma_pkg::CFG_WINDOW_LENGTH: win_nxt = bcma_pkg::len_t'(cfg_wr.data);
        bcma_pkg::CFG_INIT_X:        init_nxt.box_x = cfg_wr.data;
        bcma_pkg::CFG_INIT_Y:        init_nxt.box_y = cfg_wr.data;
        bcma_pkg::CFG_INIT_WIDTH:    init_nxt.box_width = cfg_wr.data;
        bcma_pkg::CFG_INIT_HEIGHT:   init_nxt.box_height = cfg_wr.data;
        default:                     prime_nxt = 1'b0;
      endcase
    end

    if (prime_r) begin
      ring_fill = 1'b1;
      slot_nxt  = '0;
      prev_nxt  = init_r;
      for (int k = 0; k < bcma_pkg::LANES; k++) begin
        tot_nxt[k] = bcma_pkg::total_t'(n_act) * bcma_pkg::total_t'(init_corner[k]);
      end
    end

    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty && out_free) begin
          pop           = 1'b1;
          out_valid_nxt = 1'b1;
          out_nxt.out_x      = q_head.box.box_x;
          out_nxt.out_y      = q_head.box.box_y;
          out_nxt.out_width  = q_head.box.box_width;
          out_nxt.out_height = q_head.box.box_height;
          if (q_head.zero_area) begin
            out_nxt.out_status = bcma_pkg::STATUS_EMPTY;
          end else if (!overlap) begin
            out_nxt.out_status = bcma_pkg::STATUS_NO_OVERLAP;
            prev_nxt           = q_head.box;
          end else begin
            // averaged result comes later, keep the output slot as it was
            out_valid_nxt = out_valid_r && !out_ready;
            out_nxt       = out_r;
            ring_we       = 1'b1;
            tot_nxt       = div_req.dividend;
            slot_nxt      = (slot_inc >= n_act) ? '0 : slot_inc[SB-1:0];
            div_req.start = 1'b1;
            state_nxt     = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (!div_busy && out_free) begin
          out_valid_nxt      = 1'b1;
          out_nxt.out_x      = avg_box.box_x;
          out_nxt.out_y      = avg_box.box_y;
          out_nxt.out_width  = avg_box.box_width;
          out_nxt.out_height = avg_box.box_height;
          out_nxt.out_status = bcma_pkg::STATUS_AVERAGED;
          prev_nxt           = avg_box;
          state_nxt          = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      win_r       <= bcma_pkg::len_t'(4);
      init_r      <= '0;
      prime_r     <= 1'b0;
      tot_r       <= '0;
      slot_r      <= '0;
      prev_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MW; i++) begin
        ring_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      win_r       <= win_nxt;
      init_r      <= init_nxt;
      prime_r     <= prime_nxt;
      tot_r       <= tot_nxt;
      slot_r      <= slot_nxt;
      prev_r      <= prev_nxt;
      out_valid_r <= out_valid_nxt;
      if (ring_fill) begin
        for (int i = 0; i < MW; i++) begin
          ring_r[i] <= init_corner;
        end
      end else if (ring_we) begin
        ring_r[s] <= q_head.corner;
      end
    end
    out_r <= out_nxt;
  end

endmodule
`default_nettype wire

### sv/box_corner_moving_average.sv
`default_nettype none
// Moving average of bounding-box corners over a window of 1 to 16 boxes. A box
// of zero area comes back unchanged (status 0) through the output register once
// the filter core takes it, as does a box that misses the previous output (status 1, it
// becomes the new previous box). For an averaged box (status 2) the core first
// updates the window and its running totals, then the bit-serial divider forms
// all four corner means in lockstep in 20 steps (one step per bit of a running
// total), and last the output register is loaded. Boxes
// are handled one at a time by the core; a two-entry queue in front of it keeps
// taking input meanwhile while it has room. A configuration write to indices 0 to 4
// re-primes the window in the following cycle; input is held off during the write and that cycle.
module box_corner_moving_average (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  wire                 bcma_pkg::in_box_t in_data,
  output logic                out_valid,
  input  wire                 out_ready,
  output bcma_pkg::out_box_t  out_data,
  input  wire                 cfg_we,
  input  wire  [2:0]          cfg_index,
  input  wire                 bcma_pkg::field_t cfg_data
);

  bcma_pkg::cfg_wr_t    cfg_wr;
  logic                 q_full, q_empty, q_push, q_pop, priming, div_busy;
  bcma_pkg::q_item_t    push_item, q_head;
  bcma_pkg::div_req_t   div_req;
  bcma_pkg::total_vec_t div_quotient;

  assign cfg_wr.we    = cfg_we;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.data  = cfg_data;

  bcma_front u_front (
    .in_data   (in_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .q_full    (q_full),
    .priming   (priming),
    .cfg_wr    (cfg_wr),
    .push      (q_push),
    .push_item (push_item)
  );

  bcma_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  bcma_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .busy     (div_busy),
    .quotient (div_quotient)
  );

  bcma_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr       (cfg_wr),
    .priming      (priming),
    .q_empty      (q_empty),
    .q_head       (q_head),
    .pop          (q_pop),
    .div_req      (div_req),
    .div_busy     (div_busy),
    .div_quotient (div_quotient),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data)
  );

`ifndef SYNTHESIS
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("queue written while full");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("queue read while empty");

  a_prime_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_we && cfg_index <= bcma_pkg::CFG_INIT_HEIGHT) |=> !in_ready)
    else $error("input taken during re-prime");

  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.out_status == bcma_pkg::STATUS_EMPTY)
      |-> (out_data.out_width == '0 || out_data.out_height == '0))
    else $error("empty status on a box with area");
`endif

endmodule
`default_nettype wire
